// File: design/uart_tx_pkg.sv
`timescale 1ns / 1ps

package uart_tx_pkg;

  localparam int FrameBits = 10;
  localparam int MaxChars  = 5;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] BitTicksReset = 8'd16;
  localparam logic [9:0] FrameIdle = 10'h3FF;

  typedef enum logic [1:0] {
    OP_RAW = 2'd0,
    OP_DEC = 2'd1,
    OP_HEX = 2'd2,
    OP_RSV = 2'd3
  } opcode_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CharZero + {4'd0, v};
    end else begin
      r = CharUpA + {4'd0, v - 4'd10};
    end
    return r;
  endfunction

endpackage

// File: design/uart_text_transmitter_core.sv
`timescale 1ns / 1ps

// UART text transmitter core, 8N1, LSB first, line idles high.
// Input channel (in_valid/in_ready): one transaction per bit-timer tick; a tick
// may carry a request (raw character, three decimal digits or two hex digits,
// optional CR LF at end of message). A request is taken only when the core is
// idle with an empty queue; otherwise it is dropped, as reported by ready_res.
// Result channel (out_valid/out_ready): one transaction per tick carrying the
// line level after that tick, ready_res and the message_done pulse.
// Configuration channel (cfg_valid/cfg_ready): writes bit_ticks, the number of
// ticks each serial bit is held; write only while the core is idle.
// The result of a tick is registered into the output register in the cycle after
// the tick is accepted. Throughput: one tick per cycle, set by the single state
// update between the state registers and the output register.
// When the receiver stalls, the output register holds and in_ready drops; the
// next tick is taken in the same cycle the held result is taken.
// Reset: line idle high, queue empty, no pending result, bit_ticks = 16.
module uart_text_transmitter_core #(
  parameter int QUEUE_DEPTH = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_request_valid,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_char_value,
  input  logic       in_end_of_message,
  input  logic       in_add_newline,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_line_level,
  output logic       out_ready_res,
  output logic       out_message_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]      bit_ticks_r;
  logic [7:0]      queue_r [QUEUE_DEPTH];
  logic [7:0]      queue_nxt [QUEUE_DEPTH];
  logic [CntW-1:0] count_r, count_nxt;
  logic [9:0]      frame_r, frame_nxt;
  logic [3:0]      bitpos_r, bitpos_nxt;
  logic [7:0]      countdown_r, countdown_nxt;
  logic            line_r, line_nxt;
  logic            eom_pend_r, eom_pend_nxt;
  logic            out_valid_r;
  logic            out_line_r, out_ready_res_r, out_done_r;
  logic            done_nxt;

  logic            tick;
  logic            idle;
  logic            take_req;
  logic            frame_ended;
  logic [7:0]      hold;
  logic [7:0]      first_char;
  logic [7:0]      list [QUEUE_DEPTH];
  logic [7:0]      base [3];
  logic [2:0]      n_base;
  logic [2:0]      n_total;
  logic [1:0]      hundreds;
  logic [6:0]      rem100;
  logic [15:0]     tens_prod;
  logic [3:0]      tens;
  logic [3:0]      ones;
  logic [7:0]      tens_x10;

  assign in_ready  = ~out_valid_r | out_ready;
  assign tick      = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign idle      = (bitpos_r == 4'd0) && (count_r == '0);
  assign take_req  = tick & in_request_valid & idle;
  assign hold      = (bit_ticks_r == 8'd0) ? 8'd0 : bit_ticks_r - 8'd1;

  always_comb begin
    if (in_char_value >= 8'd200) begin
      hundreds = 2'd2;
      rem100   = 7'(in_char_value - 8'd200);
    end else if (in_char_value >= 8'd100) begin
      hundreds = 2'd1;
      rem100   = 7'(in_char_value - 8'd100);
    end else begin
      hundreds = 2'd0;
      rem100   = in_char_value[6:0];
    end
    tens_prod = {9'd0, rem100} * 16'd205;
    tens      = tens_prod[14:11];
    tens_x10  = {4'd0, tens} * 8'd10;
    ones      = 4'(8'({1'b0, rem100}) - tens_x10);
  end

  always_comb begin
    base[0] = in_char_value;
    base[1] = 8'd0;
    base[2] = 8'd0;
    n_base  = 3'd1;
    case (uart_tx_pkg::opcode_t'(in_opcode))
      uart_tx_pkg::OP_DEC: begin
        base[0] = uart_tx_pkg::CharZero + {6'd0, hundreds};
        base[1] = uart_tx_pkg::CharZero + {4'd0, tens};
        base[2] = uart_tx_pkg::CharZero + {4'd0, ones};
        n_base  = 3'd3;
      end
      uart_tx_pkg::OP_HEX: begin
        base[0] = uart_tx_pkg::hex_digit(in_char_value[7:4]);
        base[1] = uart_tx_pkg::hex_digit(in_char_value[3:0]);
        n_base  = 3'd2;
      end
      default: begin
        base[0] = in_char_value;
        n_base  = 3'd1;
      end
    endcase
    n_total = (in_end_of_message & in_add_newline) ? n_base + 3'd2 : n_base;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      list[i] = 8'd0;
    end
    for (int k = 0; k < uart_tx_pkg::MaxChars; k++) begin
      if (3'(k) < n_base) begin
        list[k] = base[k % 3];
      end else if (3'(k) == n_base) begin
        list[k] = uart_tx_pkg::CharCr;
      end else begin
        list[k] = uart_tx_pkg::CharLf;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_nxt[i] = queue_r[i];
    end
    count_nxt     = count_r;
    frame_nxt     = frame_r;
    bitpos_nxt    = bitpos_r;
    countdown_nxt = countdown_r;
    line_nxt      = line_r;
    eom_pend_nxt  = eom_pend_r;
    frame_ended   = 1'b0;
    done_nxt      = 1'b0;
    first_char    = 8'd0;

    if (take_req) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (i < uart_tx_pkg::MaxChars && 3'(i) < n_total) begin
          queue_nxt[i] = list[i];
        end
      end
      count_nxt    = CntW'(n_total);
      eom_pend_nxt = in_end_of_message;
    end

    if (tick) begin
      if (bitpos_r != 4'd0) begin
        if (countdown_r != 8'd0) begin
          countdown_nxt = countdown_r - 8'd1;
        end else begin
          frame_nxt  = {1'b1, frame_r[9:1]};
          bitpos_nxt = bitpos_r + 4'd1;
          if (bitpos_nxt > 4'(uart_tx_pkg::FrameBits)) begin
            bitpos_nxt  = 4'd0;
            line_nxt    = 1'b1;
            frame_ended = 1'b1;
          end else begin
            line_nxt      = frame_nxt[0];
            countdown_nxt = hold;
          end
        end
      end

      if (bitpos_nxt == 4'd0) begin
        if (count_nxt != '0) begin
          first_char = queue_nxt[0];
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            queue_nxt[i] = queue_nxt[i + 1];
          end
          count_nxt     = count_nxt - CntW'(1);
          frame_nxt     = {1'b1, first_char, 1'b0};
          bitpos_nxt    = 4'd1;
          line_nxt      = 1'b0;
          countdown_nxt = hold;
        end else if (frame_ended && eom_pend_nxt) begin
          done_nxt     = 1'b1;
          eom_pend_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r <= uart_tx_pkg::BitTicksReset;
      count_r     <= '0;
      frame_r     <= uart_tx_pkg::FrameIdle;
      bitpos_r    <= 4'd0;
      countdown_r <= 8'd0;
      line_r      <= 1'b1;
      eom_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bit_ticks_r <= cfg_data;
      end
      count_r     <= count_nxt;
      frame_r     <= frame_nxt;
      bitpos_r    <= bitpos_nxt;
      countdown_r <= countdown_nxt;
      line_r      <= line_nxt;
      eom_pend_r  <= eom_pend_nxt;
      if (tick) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_r[i] <= queue_nxt[i];
    end
    if (tick) begin
      out_line_r      <= line_nxt;
      out_ready_res_r <= idle;
      out_done_r      <= done_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_level   = out_line_r;
  assign out_ready_res    = out_ready_res_r;
  assign out_message_done = out_done_r;

endmodule

// File: design/uart_tx_checker.sv
`timescale 1ns / 1ps

module uart_tx_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_line_level,
  input logic out_ready_res,
  input logic out_message_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_level)
      && $stable(out_ready_res) && $stable(out_message_done))
    else $error("result changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result register full");

  a_done_idle_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_done |-> out_line_level && !out_ready_res)
    else $error("message done with line active or core ready");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind uart_text_transmitter_core uart_tx_checker u_uart_tx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_line_level   (out_line_level),
  .out_ready_res    (out_ready_res),
  .out_message_done (out_message_done)
);
